### rtl/bsep_pkg.sv
// shared types and constants of the bounded stack with even purge
package bsep_pkg;

    // fixed field widths
    localparam int OP_W        = 2;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // operation codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_PURGE = 2'd3
    } t_op;

    // status codes of a result item
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PEEK,
        S_COUNT,
        S_SCAN
    } t_state;

    // store read select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_TOP,
        RD_FIRST,
        RD_NEXT
    } t_rd_sel;

    // output register load select
    typedef enum logic [2:0] {
        OUT_HOLD,
        OUT_IMM,
        OUT_PEEK,
        OUT_NONE_FOUND,
        OUT_EVEN
    } t_out_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic     do_op;
        t_rd_sel  rd_sel;
        logic     cnt_clr;
        logic     cnt_en;
        logic     wr_odd;
        logic     ev_inc;
        logic     commit_fill;
        t_out_sel out_sel;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic fill_zero;
        logic at_end;
        logic rd_odd;
        logic no_evens;
        logic out_free;
    } t_stat;

endpackage

### rtl/bsep_ctrl.sv
// controller state machine of the bounded stack with even purge
module bsep_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bsep_pkg::t_stat i_stat,
    output bsep_pkg::t_cmd  o_cmd
);

    bsep_pkg::t_state r_state;
    bsep_pkg::t_state n_state;
    logic             w_accept;

    // input item taken only when idle and the output register can take a result
    assign o_in_ready = (r_state == bsep_pkg::S_IDLE) && i_stat.out_free;
    assign w_accept   = o_in_ready && i_in_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsep_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsep_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_stat.op)
                        bsep_pkg::OP_PEEK: begin
                            if (!i_stat.fill_zero) n_state = bsep_pkg::S_PEEK;
                        end
                        bsep_pkg::OP_PURGE: begin
                            if (!i_stat.fill_zero) n_state = bsep_pkg::S_COUNT;
                        end
                        default: n_state = bsep_pkg::S_IDLE;
                    endcase
                end
            end
            bsep_pkg::S_PEEK: n_state = bsep_pkg::S_IDLE;
            bsep_pkg::S_COUNT: begin
                if (i_stat.at_end) begin
                    n_state = i_stat.no_evens ? bsep_pkg::S_IDLE : bsep_pkg::S_SCAN;
                end
            end
            bsep_pkg::S_SCAN: begin
                if ((i_stat.rd_odd || i_stat.out_free) && i_stat.at_end) begin
                    n_state = bsep_pkg::S_IDLE;
                end
            end
            default: n_state = bsep_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel  = bsep_pkg::RD_NONE;
        o_cmd.out_sel = bsep_pkg::OUT_HOLD;
        unique case (r_state)
            bsep_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_stat.op)
                        bsep_pkg::OP_PUSH, bsep_pkg::OP_POP: begin
                            o_cmd.do_op   = 1'b1;
                            o_cmd.out_sel = bsep_pkg::OUT_IMM;
                        end
                        bsep_pkg::OP_PEEK: begin
                            if (i_stat.fill_zero) begin
                                o_cmd.out_sel = bsep_pkg::OUT_IMM;
                            end else begin
                                o_cmd.rd_sel = bsep_pkg::RD_TOP;
                            end
                        end
                        default: begin
                            if (i_stat.fill_zero) begin
                                o_cmd.out_sel = bsep_pkg::OUT_NONE_FOUND;
                            end else begin
                                o_cmd.rd_sel  = bsep_pkg::RD_FIRST;
                                o_cmd.cnt_clr = 1'b1;
                            end
                        end
                    endcase
                end
            end
            bsep_pkg::S_PEEK: o_cmd.out_sel = bsep_pkg::OUT_PEEK;
            bsep_pkg::S_COUNT: begin
                o_cmd.cnt_en = 1'b1;
                if (!i_stat.at_end) begin
                    o_cmd.rd_sel = bsep_pkg::RD_NEXT;
                end else if (i_stat.no_evens) begin
                    o_cmd.out_sel = bsep_pkg::OUT_NONE_FOUND;
                end else begin
                    o_cmd.rd_sel = bsep_pkg::RD_FIRST;
                end
            end
            bsep_pkg::S_SCAN: begin
                if (i_stat.rd_odd || i_stat.out_free) begin
                    if (i_stat.rd_odd) begin
                        o_cmd.wr_odd = 1'b1;
                    end else begin
                        o_cmd.ev_inc  = 1'b1;
                        o_cmd.out_sel = bsep_pkg::OUT_EVEN;
                    end
                    if (i_stat.at_end) begin
                        o_cmd.commit_fill = 1'b1;
                    end else begin
                        o_cmd.rd_sel = bsep_pkg::RD_NEXT;
                    end
                end
            end
            default: o_cmd.out_sel = bsep_pkg::OUT_HOLD;
        endcase
    end

endmodule

### rtl/bsep_dpath.sv
// datapath of the bounded stack: word store, counters and output register
module bsep_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsep_pkg::t_cmd                      i_cmd,
    output bsep_pkg::t_stat                     o_stat,
    input  logic [bsep_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [bsep_pkg::OUT_TDATA_W-1:0]    o_out_tdata,
    output logic                                o_out_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [bsep_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [bsep_pkg::WORD_W-1:0] r_rdata;

    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_wr;
    logic [CW-1:0] r_odd_tot;
    logic [CW-1:0] r_ev_tot;
    logic [CW-1:0] r_ev_done;

    logic                          r_out_valid;
    bsep_pkg::t_status             r_out_status;
    logic signed [bsep_pkg::WORD_W-1:0] r_out_word;
    logic [bsep_pkg::FILL_W-1:0]   r_out_fill;
    logic                          r_out_last;

    bsep_pkg::t_op                 w_op;
    logic signed [bsep_pkg::WORD_W-1:0] w_value;
    logic [CW-1:0]                 w_top;
    logic                          w_full;
    logic                          w_zero;
    logic                          w_out_free;
    bsep_pkg::t_status             w_imm_status;
    logic [AW-1:0]                 w_rd_addr;
    logic                          w_rd_en;

    // input item fields
    assign w_op    = bsep_pkg::t_op'(i_in_tdata[bsep_pkg::OP_W-1:0]);
    assign w_value = i_in_tdata[bsep_pkg::OP_W +: bsep_pkg::WORD_W];

    assign w_top      = r_fill - CW'(1);
    assign w_full     = (r_fill == CW'(DEPTH));
    assign w_zero     = (r_fill == '0);
    assign w_out_free = !r_out_valid || i_out_ready;

    // status to controller
    always_comb begin
        o_stat.op        = w_op;
        o_stat.fill_zero = w_zero;
        o_stat.at_end    = (CW'(r_idx) == w_top);
        o_stat.rd_odd    = r_rdata[0];
        o_stat.no_evens  = (r_ev_tot == '0) && r_rdata[0];
        o_stat.out_free  = w_out_free;
    end

    // fill count after a push, a pop or the commit of a purge compaction
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.do_op && (w_op == bsep_pkg::OP_PUSH) && !w_full) begin
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.do_op && (w_op == bsep_pkg::OP_POP) && !w_zero) begin
            n_fill = w_top;
        end else if (i_cmd.commit_fill) begin
            n_fill = r_odd_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // store write: push at top, compaction of odd words at the write index
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_op && (w_op == bsep_pkg::OP_PUSH) && !w_full) begin
            r_mem[r_fill[AW-1:0]] <= w_value;
        end else if (i_cmd.wr_odd) begin
            r_mem[r_wr] <= r_rdata;
        end
    end

    // store read address
    always_comb begin
        w_rd_en   = 1'b1;
        w_rd_addr = '0;
        unique case (i_cmd.rd_sel)
            bsep_pkg::RD_TOP:   w_rd_addr = w_top[AW-1:0];
            bsep_pkg::RD_FIRST: w_rd_addr = '0;
            bsep_pkg::RD_NEXT:  w_rd_addr = r_idx + AW'(1);
            default:            w_rd_en   = 1'b0;
        endcase
    end

    // registered read, held while no new read is issued
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
            r_idx   <= w_rd_addr;
        end
    end

    // purge counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_odd_tot <= '0;
            r_ev_tot  <= '0;
            r_ev_done <= '0;
            r_wr      <= '0;
        end else begin
            if (i_cmd.cnt_en) begin
                if (r_rdata[0]) begin
                    r_odd_tot <= r_odd_tot + CW'(1);
                end else begin
                    r_ev_tot <= r_ev_tot + CW'(1);
                end
            end
            if (i_cmd.wr_odd) r_wr <= r_wr + AW'(1);
            if (i_cmd.ev_inc) r_ev_done <= r_ev_done + CW'(1);
        end
    end

    // status of a single-result operation
    always_comb begin
        unique case (w_op)
            bsep_pkg::OP_PUSH: w_imm_status = w_full ? bsep_pkg::ST_FULL : bsep_pkg::ST_OK;
            bsep_pkg::OP_POP:  w_imm_status = w_zero ? bsep_pkg::ST_EMPTY : bsep_pkg::ST_OK;
            default:           w_imm_status = bsep_pkg::ST_EMPTY;
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_sel != bsep_pkg::OUT_HOLD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_sel)
            bsep_pkg::OUT_IMM: begin
                r_out_status <= w_imm_status;
                r_out_word   <= '0;
                r_out_fill   <= bsep_pkg::FILL_W'(n_fill);
                r_out_last   <= 1'b1;
            end
            bsep_pkg::OUT_PEEK: begin
                r_out_status <= bsep_pkg::ST_OK;
                r_out_word   <= r_rdata;
                r_out_fill   <= bsep_pkg::FILL_W'(r_fill);
                r_out_last   <= 1'b1;
            end
            bsep_pkg::OUT_NONE_FOUND: begin
                r_out_status <= bsep_pkg::ST_NONE;
                r_out_word   <= '0;
                r_out_fill   <= bsep_pkg::FILL_W'(r_fill);
                r_out_last   <= 1'b1;
            end
            bsep_pkg::OUT_EVEN: begin
                r_out_status <= bsep_pkg::ST_OK;
                r_out_word   <= r_rdata;
                r_out_fill   <= bsep_pkg::FILL_W'(r_odd_tot);
                r_out_last   <= ((r_ev_done + CW'(1)) == r_ev_tot);
            end
            default: begin
                r_out_status <= r_out_status;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tlast = r_out_last;
    assign o_out_tdata = {
        {(bsep_pkg::OUT_TDATA_W - bsep_pkg::STATUS_W - bsep_pkg::WORD_W
          - bsep_pkg::FILL_W){1'b0}},
        r_out_fill,
        r_out_word,
        r_out_status
    };

    // fill count never exceeds the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_sel != bsep_pkg::OUT_HOLD) |-> w_out_free)
        else $error("result register overwritten");

    // compaction never writes ahead of the scan
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_odd |-> (r_wr <= r_idx))
        else $error("compaction write passed scan index");

    // never more even words emitted than counted
    a_even_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_sel == bsep_pkg::OUT_EVEN) |-> (r_ev_done < r_ev_tot))
        else $error("even word emitted beyond count");

endmodule

### rtl/bounded_stack_with_even_purge_top.sv
// top level of the bounded stack with even purge
//
//  channel   dir  tdata fields (low bit up)               tlast
//  s_axis    in   op[1:0] value[33:2]                     -
//  m_axis    out  status[1:0] word[33:2] fill_level[38:34] last of the item's results
//
// push and pop load their result on acceptance; peek makes one store read of the top word and then loads it.
// purge on an empty stack loads its result on acceptance; otherwise acceptance
// is followed by a counting pass over the stored words, and when evens are present by a
// compaction pass over them that stalls on each even word while the output is busy.
// reset clears the fill count, the controller and the output valid; store
// contents stay as they are and are never read before being written.
// a stalled result holds in the output register; purge waits on each even word.
module bounded_stack_with_even_purge_top #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bsep_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // op, value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bsep_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // status, word, fill_level
    output logic                             m_axis_tlast
);

    bsep_pkg::t_cmd  w_cmd;
    bsep_pkg::t_stat w_stat;

    // controller
    bsep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    bsep_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_tdata  (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tlast (m_axis_tlast)
    );

endmodule
